// ===== design/lsfc_pkg.sv =====
// Shared types and constants for the low-charge fast-charge current policy.
`timescale 1ns / 1ps

package lsfc_pkg;

   // Action codes carried in the request beat.
   localparam logic [1:0] ACT_TICK      = 2'd0;
   localparam logic [1:0] ACT_LOAD_FAST = 2'd1;
   localparam logic [1:0] ACT_LOAD_MIT  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FAST_ENABLE = 2'd0;
   localparam logic [1:0] CSR_TABLE_ERROR = 2'd1;
   localparam logic [1:0] CSR_MAX_LEVEL   = 2'd2;

   localparam logic [3:0] MAX_LEVEL_RESET = 4'd15;

   // Policy thresholds.
   localparam logic [6:0]         SOC_FAST_LIMIT   = 7'd40;
   localparam logic [31:0]        BRIGHT_WINDOW_S  = 32'd10;
   localparam logic signed [11:0] HOT_HOLD_TEMP_DC = 12'sd410;
   localparam logic signed [11:0] FAST_CUTOFF_DC   = 12'sd420;
   localparam logic [3:0]         LEVEL_HOT        = 4'd8;
   localparam logic [3:0]         LEVEL_WARM       = 4'd7;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         entry_index;
      logic [14:0]        entry_current_ma;
      logic [3:0]         heat_level;
      logic [6:0]         charge_percent;
      logic               source_is_pps;
      logic               plugged_for_fast;
      logic               screen_lit;
      logic signed [11:0] board_temp_dc;
      logic [31:0]        now_seconds;
   } lsfc_req_type;

   typedef struct packed {
      logic        limit_valid;
      logic [14:0] current_limit_ma;
      logic        fast_mode;
      logic        feature_active;
   } lsfc_rsp_type;

   typedef struct packed {
      logic       fast_enable;
      logic       table_error;
      logic [3:0] max_level;
   } lsfc_cfg_type;

endpackage

// ===== design/lsfc_tables.sv =====
// Fast and mitigation current tables, one write port and one registered read each.
`timescale 1ns / 1ps

module lsfc_tables #(
   parameter int LEVEL_COUNT = 16
) (
   input  logic                           clock,
   input  logic                           wr_fast,
   input  logic                           wr_mit,
   input  logic [$clog2(LEVEL_COUNT)-1:0] wr_addr,
   input  logic [14:0]                    wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(LEVEL_COUNT)-1:0] rd_addr,
   output logic [14:0]                    fast_rd,
   output logic [14:0]                    mit_rd
);
   import lsfc_pkg::*;

   logic [14:0] fast_mem [LEVEL_COUNT];
   logic [14:0] mit_mem  [LEVEL_COUNT];
   logic [14:0] fast_rd_ff;
   logic [14:0] mit_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_fast) begin
         fast_mem[wr_addr] <= wr_data;
      end
      if (wr_mit) begin
         mit_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         fast_rd_ff <= fast_mem[rd_addr];
         mit_rd_ff  <= mit_mem[rd_addr];
      end
   end

   assign fast_rd = fast_rd_ff;
   assign mit_rd  = mit_rd_ff;

endmodule

// ===== design/lsfc_decide.sv =====
// Per-tick decision logic together with the screen tracker, hot hold and mode flags.
`timescale 1ns / 1ps

module lsfc_decide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  lsfc_pkg::lsfc_req_type item,
   input  lsfc_pkg::lsfc_cfg_type cfg,
   input  logic [14:0]           fast_rd,
   input  logic [14:0]           mit_rd,
   output lsfc_pkg::lsfc_rsp_type rsp
);
   import lsfc_pkg::*;

   typedef enum logic [1:0] {
      PH_DEFAULT,
      PH_BLACK,
      PH_TO_BRIGHT,
      PH_BRIGHT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] start_ff, start_in;
   logic [3:0]  prev_level_ff, prev_level_in;
   logic        hot_ff, hot_in;
   logic        mode_ff, mode_in;
   logic        active_ff, active_in;

   logic        is_tick, qualify, err, run;
   logic        screen_ok, hot_block, fast;
   logic        temp_warm;
   logic [31:0] delta;

   always_comb begin
      phase_in      = phase_ff;
      start_in      = start_ff;
      prev_level_in = prev_level_ff;
      hot_in        = hot_ff;
      mode_in       = mode_ff;
      active_in     = active_ff;
      screen_ok     = 1'b1;
      hot_block     = 1'b0;

      is_tick = (item.action == ACT_TICK);
      qualify = item.source_is_pps && (item.charge_percent <= SOC_FAST_LIMIT) &&
                item.plugged_for_fast && cfg.fast_enable;
      err = is_tick && ((item.heat_level == 4'd0) ||
            (qualify && (cfg.table_error || (item.heat_level > cfg.max_level))));
      run = is_tick && !err && qualify;
      delta = item.now_seconds - start_ff;
      temp_warm = (item.board_temp_dc > HOT_HOLD_TEMP_DC);

      if (err) begin
         prev_level_in = item.heat_level;
      end

      if (run) begin
         // Screen tracker: fast mode is allowed for a short window after turn-on.
         if (item.screen_lit && (phase_ff == PH_DEFAULT || phase_ff == PH_BLACK)) begin
            phase_in = PH_TO_BRIGHT;
            start_in = item.now_seconds;
         end else if (item.screen_lit) begin
            phase_in  = PH_BRIGHT;
            screen_ok = (delta <= BRIGHT_WINDOW_S);
         end else begin
            phase_in = PH_BLACK;
         end

         // Hot hold starts on a drop from level 8 to 7 while warm.
         if (prev_level_ff == LEVEL_HOT && item.heat_level == LEVEL_WARM && temp_warm) begin
            hot_in    = 1'b1;
            hot_block = 1'b1;
         end else if (prev_level_ff == LEVEL_WARM &&
                      (item.heat_level == LEVEL_WARM || item.heat_level == LEVEL_HOT) &&
                      hot_ff && temp_warm) begin
            hot_block = 1'b1;
         end else begin
            hot_in = 1'b0;
         end

         prev_level_in = item.heat_level;
      end

      fast = screen_ok && !hot_block && !(item.board_temp_dc > FAST_CUTOFF_DC);

      if (run) begin
         mode_in   = fast;
         active_in = fast;
      end

      rsp.limit_valid      = err || run;
      rsp.current_limit_ma = err ? mit_rd : (run ? (fast ? fast_rd : mit_rd) : 15'd0);
      rsp.fast_mode        = mode_in;
      rsp.feature_active   = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DEFAULT;
         start_ff      <= '0;
         prev_level_ff <= '0;
         hot_ff        <= 1'b0;
         mode_ff       <= 1'b0;
         active_ff     <= 1'b0;
      end else if (commit) begin
         phase_ff      <= phase_in;
         start_ff      <= start_in;
         prev_level_ff <= prev_level_in;
         hot_ff        <= hot_in;
         mode_ff       <= mode_in;
         active_ff     <= active_in;
      end
   end

endmodule

// ===== design/low_soc_fast_charge_policy.sv =====
// Top level of the low-charge fast-charge current policy.
`timescale 1ns / 1ps

// Every request beat yields exactly one response beat. A tick beat picks a
// charge-current limit from the fast table or the mitigation table, indexed
// by the thermal level (levels past the table end use the last entry); load
// beats write one table entry when its index is in range and answer with
// limit_valid low and the mode flags unchanged. The block is a two-register
// pipeline: the table read is launched as the request is accepted, the
// decision is made from the input register and the read data, and the
// response register holds the result. One beat is accepted every cycle
// while the response side is not stalled. An accepted request waits in the
// input register and moves on once the response register is free or being
// emptied; the response register decouples the sides so a new request is
// still taken while a finished response waits and the input register is
// empty. Table entries power up undefined and must be loaded before a tick
// reads them. Configuration writes are taken at any time (csr_ready is
// always high) but should be issued only while no beat is in flight.

module low_soc_fast_charge_policy #(
   parameter int LEVEL_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  lsfc_pkg::lsfc_req_type req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lsfc_pkg::lsfc_rsp_type rsp_data,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_wdata
);
   import lsfc_pkg::*;

   localparam int IDX_W = $clog2(LEVEL_COUNT);

   lsfc_cfg_type cfg_ff;
   logic         s1_valid_ff, s1_valid_in;
   lsfc_req_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   lsfc_rsp_type rsp_data_ff;
   lsfc_rsp_type rsp_next;

   logic             req_accept, advance;
   logic [6:0]       level_ext, eidx_ext;
   logic             entry_in_range;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_fast, wr_mit, rd_en;
   logic [14:0]      fast_rd, mit_rd;

   // The input register moves on whenever the response register is free
   // or is being emptied this cycle.
   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Table addressing straight off the request beat, so the read data is
   // ready alongside the input register.
   assign level_ext      = 7'(req_data.heat_level);
   assign eidx_ext       = 7'(req_data.entry_index);
   assign rd_addr        = (level_ext < 7'(LEVEL_COUNT)) ? IDX_W'(req_data.heat_level)
                                                         : IDX_W'(LEVEL_COUNT - 1);
   assign wr_addr        = IDX_W'(req_data.entry_index);
   assign entry_in_range = (eidx_ext < 7'(LEVEL_COUNT));
   assign wr_fast = req_accept && entry_in_range && (req_data.action == ACT_LOAD_FAST);
   assign wr_mit  = req_accept && entry_in_range && (req_data.action == ACT_LOAD_MIT);
   assign rd_en   = req_accept && (req_data.action == ACT_TICK);

   lsfc_tables #(
      .LEVEL_COUNT(LEVEL_COUNT)
   ) u_tables (
      .clock  (clock),
      .wr_fast(wr_fast),
      .wr_mit (wr_mit),
      .wr_addr(wr_addr),
      .wr_data(req_data.entry_current_ma),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .fast_rd(fast_rd),
      .mit_rd (mit_rd)
   );

   lsfc_decide u_decide (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .fast_rd(fast_rd),
      .mit_rd (mit_rd),
      .rsp    (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         cfg_ff.fast_enable  <= 1'b0;
         cfg_ff.table_error  <= 1'b0;
         cfg_ff.max_level    <= MAX_LEVEL_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FAST_ENABLE: cfg_ff.fast_enable <= csr_wdata[0];
               CSR_TABLE_ERROR: cfg_ff.table_error <= csr_wdata[0];
               CSR_MAX_LEVEL:   cfg_ff.max_level   <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The request side only stalls while it holds a beat of its own.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty input register");

   // A beat leaving the input register always lands in the response register.
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("advanced beat did not reach the response register");

   // Both mode flags are always updated together.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (rsp_data_ff.fast_mode == rsp_data_ff.feature_active))
      else $error("fast_mode and feature_active disagree");

   // No limit is reported without limit_valid.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_data_ff.limit_valid) |->
                    (rsp_data_ff.current_limit_ma == 15'd0))
      else $error("current limit issued without limit_valid");

endmodule
